// ===== rtl/lcdexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Character display expander package
// Item, result and internal display-byte types, command codes and the
// display row base address table.
// ----------------------------------------------------------------------------
package lcdexp_pkg;

	typedef struct packed {
		logic       command;
		logic [3:0] column;
		logic [1:0] row;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic [7:0] expander_byte;
		logic       last;
	} result_t;

	// One display byte waiting to be sent as six expander bytes
	typedef struct packed {
		logic [7:0] data;
		logic       rs;
		logic       last;
	} op_t;

	localparam logic       CmdChar     = 1'b0;
	localparam logic       CmdCursor   = 1'b1;
	localparam logic [7:0] SetAddr     = 8'h80;
	localparam logic [7:0] CharNewline = 8'd10;
	localparam logic [7:0] CharReturn  = 8'd13;

	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			2'd3:    b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lcdexp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Character display expander front end
// Accepts items, keeps the cursor and turns each item into one or two
// display bytes for the queue.
// ----------------------------------------------------------------------------
module lcdexp_front #(
	parameter int LINE_LENGTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  wire lcdexp_pkg::item_t   item,
	output logic                     q_wr_en,
	output lcdexp_pkg::op_t          q_wr_op,
	input  wire                      q_full
);
	import lcdexp_pkg::*;

	// set-cursor may leave the column at 15 even for short lines
	localparam int ColMax = (LINE_LENGTH > 15) ? LINE_LENGTH : 15;
	localparam int ColW   = $clog2(ColMax + 1);
	localparam logic [ColW-1:0] LineLen = ColW'(LINE_LENGTH);

	logic [ColW-1:0] col_q, col_w, col_n;
	logic [1:0]      row_q, row_w, row_n;
	op_t             pend_q, wrap_op, main_op;
	logic            pend_valid_q;
	logic            accept, wrap;

	function automatic logic [7:0] addr_cmd(input logic [ColW-1:0] c, input logic [1:0] r);
		return SetAddr | (8'(c) + row_base(r));
	endfunction

	assign full   = pend_valid_q || q_full;
	assign accept = push && !full;
	assign wrap   = (item.command == CmdChar) && (col_q >= LineLen);

	always_comb begin
		col_w        = wrap ? '0 : col_q;
		row_w        = wrap ? row_q + 2'd1 : row_q;
		wrap_op.data = addr_cmd('0, row_w);
		wrap_op.rs   = 1'b0;
		wrap_op.last = 1'b0;
		main_op.last = 1'b1;
		if (item.command == CmdCursor) begin
			col_n        = ColW'(item.column);
			row_n        = item.row;
			main_op.data = addr_cmd(col_n, row_n);
			main_op.rs   = 1'b0;
		end else begin
			case (item.char_code)
				CharNewline: begin
					col_n        = col_w;
					row_n        = row_w + 2'd1;
					main_op.data = addr_cmd(col_n, row_n);
					main_op.rs   = 1'b0;
				end
				CharReturn: begin
					col_n        = '0;
					row_n        = row_w;
					main_op.data = addr_cmd(col_n, row_n);
					main_op.rs   = 1'b0;
				end
				default: begin
					col_n        = col_w + ColW'(1);
					row_n        = row_w;
					main_op.data = item.char_code;
					main_op.rs   = 1'b1;
				end
			endcase
		end
	end

	// the wrap command goes first; hold the item's own byte until the queue takes it
	assign q_wr_en = (pend_valid_q && !q_full) || accept;
	assign q_wr_op = pend_valid_q ? pend_q : (wrap ? wrap_op : main_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			col_q        <= col_n;
			row_q        <= row_n;
			pend_valid_q <= wrap;
		end else if (pend_valid_q && !q_full) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= main_op;
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= ColMax)
		else $error("cursor column beyond its range");

endmodule
`default_nettype wire

// ===== rtl/lcdexp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Display byte queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module lcdexp_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_en,
	input  wire lcdexp_pkg::op_t  wr_op,
	output logic                  q_full,
	input  wire                   rd_en,
	output lcdexp_pkg::op_t       rd_op,
	output logic                  q_empty
);
	import lcdexp_pkg::*;

	op_t              entry_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign q_full  = (count_q == QCntW'(QueueDepth));
	assign q_empty = (count_q == '0);
	assign rd_op   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_op;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full))
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && q_empty))
		else $error("read from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/lcdexp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Character display expander back end
// Sends each display byte as two nibbles, each as plain, enable-high and
// enable-low expander bytes, through an output register.
// ----------------------------------------------------------------------------
module lcdexp_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   backlight,
	input  wire                   q_empty,
	input  wire lcdexp_pkg::op_t  q_rd_op,
	output logic                  q_rd_en,
	output logic                  empty,
	input  wire                   pop,
	output lcdexp_pkg::result_t   result
);
	import lcdexp_pkg::*;

	localparam logic [1:0] PhPlain  = 2'd0;
	localparam logic [1:0] PhEnHigh = 2'd1;
	localparam logic [1:0] PhEnLow  = 2'd2;

	op_t        op_q;
	logic       op_valid_q;
	logic       half_q;
	logic [1:0] phase_q;
	result_t    out_q;
	logic       out_valid_q;
	logic       advance, beat_last, op_done;
	logic [3:0] nibble;
	logic [7:0] byte_n;

	assign advance   = op_valid_q && (!out_valid_q || pop);
	assign beat_last = half_q && (phase_q == PhEnLow);
	assign op_done   = advance && beat_last;
	assign q_rd_en   = !q_empty && (!op_valid_q || op_done);

	assign nibble = half_q ? op_q.data[3:0] : op_q.data[7:4];
	assign byte_n = {nibble, backlight, (phase_q == PhEnHigh), 1'b0, op_q.rs};

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_q  <= 1'b0;
			half_q      <= 1'b0;
			phase_q     <= PhPlain;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd_en) begin
				op_valid_q <= 1'b1;
			end else if (op_done) begin
				op_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				case (phase_q)
					PhPlain:  phase_q <= PhEnHigh;
					PhEnHigh: phase_q <= PhEnLow;
					default: begin
						phase_q <= PhPlain;
						half_q  <= ~half_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd_en) begin
			op_q <= q_rd_op;
		end
		if (advance) begin
			out_q.expander_byte <= byte_n;
			out_q.last          <= op_q.last && beat_last;
		end
	end

	a_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		!op_valid_q |-> (phase_q == PhPlain) && !half_q)
		else $error("sequencer not at the first beat while idle");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("illegal beat phase");

endmodule
`default_nettype wire

// ===== rtl/char_lcd_text_to_expander_bytes.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Character display text to port expander bytes
// Keeps the cursor of a four-row character display and turns text and
// set-cursor items into expander bytes for a 4-bit display interface.
// ----------------------------------------------------------------------------
// The first expander byte of an item passes through the queue, the back-end
// display-byte register and the output register. One expander byte per cycle
// while results are popped and display bytes wait; an item yields 6 or 12 bytes.
// The front end runs ahead through a four-entry queue of display bytes.
// Reset clears the cursor to column 0, row 0, empties the queue and sets the
// backlight register to 1.
module char_lcd_text_to_expander_bytes #(
	parameter int LINE_LENGTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire                      cfg_wr_data,
	input  wire                      push,
	output logic                     full,
	input  wire lcdexp_pkg::item_t   item,
	output logic                     empty,
	input  wire                      pop,
	output lcdexp_pkg::result_t      result
);
	import lcdexp_pkg::*;

	logic backlight_q;
	logic q_wr_en, q_rd_en, q_full, q_empty;
	op_t  q_wr_op, q_rd_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (cfg_wr_en) begin
			backlight_q <= cfg_wr_data;
		end
	end

	lcdexp_front #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_wr_en (q_wr_en),
		.q_wr_op (q_wr_op),
		.q_full  (q_full)
	);

	lcdexp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_op   (q_wr_op),
		.q_full  (q_full),
		.rd_en   (q_rd_en),
		.rd_op   (q_rd_op),
		.q_empty (q_empty)
	);

	lcdexp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.backlight (backlight_q),
		.q_empty   (q_empty),
		.q_rd_op   (q_rd_op),
		.q_rd_en   (q_rd_en),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
